>>> design/gscc_pkg.sv
// Package for the greedy sphere cover center engine.
// Holds the item and result types, the link passed between distance cells,
// the state and register index enums, and the fixed field widths.
`timescale 1ns / 1ps

package gscc_pkg;

	localparam int COORD_W    = 16;
	localparam int RADIUS_W   = 39;
	localparam int DIMS_W     = 5;
	localparam int INDEX_W    = 24;
	localparam int SLOT_OUT_W = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 39;
	localparam int SQ_W       = 2 * (COORD_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 1'b0,
		REG_DIMS   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        point_index;
		logic signed [COORD_W-1:0] coordinate;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [INDEX_W-1:0]    point_echo;
		logic                  new_center;
		logic [SLOT_OUT_W-1:0] center_slot;
		logic                  store_full;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic                big;
		logic [RADIUS_W-1:0] sum;
	} link_t;

endpackage

>>> design/gscc_cell.sv
// One distance cell: holds one coordinate of the point under test, squares its
// difference to the matching center coordinate and adds it to the running sum.
// Depends on gscc_pkg.
`timescale 1ns / 1ps

module gscc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         flush,
	input  logic                         load_en,
	input  logic [gscc_pkg::COORD_W-1:0] load_coord,
	input  logic                         active,
	input  logic [gscc_pkg::COORD_W-1:0] ctr_coord,
	input  gscc_pkg::link_t              link_in,
	output gscc_pkg::link_t              link_out,
	output logic [gscc_pkg::COORD_W-1:0] coord
);
	import gscc_pkg::*;

	logic [COORD_W-1:0]        pt_q;
	link_t                     link_q;
	logic signed [COORD_W:0]   diff;
	logic [COORD_W:0]          mag;
	logic [SQ_W-1:0]           sq;
	logic [RADIUS_W:0]         acc;

	always_comb begin
		diff = $signed({pt_q[COORD_W-1], pt_q}) - $signed({ctr_coord[COORD_W-1], ctr_coord});
		mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
		sq   = active ? SQ_W'(mag) * SQ_W'(mag) : '0;
		acc  = (RADIUS_W+1)'(link_in.sum) + (RADIUS_W+1)'(sq);
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			pt_q <= load_coord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (flush) begin
			link_q <= '0;
		end else begin
			link_q.valid <= link_in.valid;
			link_q.big   <= link_in.big | acc[RADIUS_W];
			link_q.sum   <= acc[RADIUS_W-1:0];
		end
	end

	assign link_out = link_q;
	assign coord    = pt_q;

endmodule

>>> design/greedy_sphere_cover_centers_top.sv
// Top level of the greedy sphere cover center engine.
// Holds the center memory, the control sequencer and the row of distance cells.
// Depends on gscc_pkg and gscc_cell.
`timescale 1ns / 1ps

// Usage: a point arrives as dimensions_in_use items, one coordinate per item,
// taken at an edge with start high and busy low. Items before the last
// coordinate of a point are absorbed and give no result.
// The last coordinate starts the decision. With no stored centers the result
// is ready at once and done pulses in the next cycle. Otherwise busy rises
// and the stored centers are streamed, one per cycle, through a row of
// MAX_DIMS cells that each add one squared coordinate difference; the scan
// ends at the first covering center or after the last stored one. Done is
// registered after the check of the covering slot, or of the last stored
// one when nothing covers the point; the center memory read port and the
// cell chain lie between the read of a slot and its check.
// Done is high for one cycle, result until the next; receiver cannot stall.
// The next point may start in the cycle that done is high.
// Reset empties the center store, clears the coordinate count and sets the
// radius to zero and the dimension count to two. The user writes registers
// with cfg_we, cfg_idx, cfg_data while no point is in progress; unenforced.

module greedy_sphere_cover_centers_top #(
	parameter int MAX_CENTERS = 1024,
	parameter int MAX_DIMS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  gscc_pkg::point_t                point,
	output logic                            done,
	output gscc_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [gscc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gscc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gscc_pkg::*;

	localparam int SLOT_W = $clog2(MAX_CENTERS);
	localparam int CNT_W  = $clog2(MAX_CENTERS + 1);
	localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCNT_W = $clog2(MAX_DIMS + 1);
	localparam int ROW_W  = MAX_DIMS * COORD_W;

	logic [RADIUS_W-1:0] radius_q;
	logic [DIMS_W-1:0]   dims_q;
	logic [DCNT_W-1:0]   dims_eff;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [POS_W-1:0]    pos_q;
	logic [INDEX_W-1:0]  pid_q;
	logic                last_q;
	logic [CNT_W-1:0]    rd_slot_q;
	logic [SLOT_W-1:0]   chk_slot_q;
	logic                tag_s1;
	logic                done_q;
	result_t             res_q;

	logic [ROW_W-1:0]    ctr_mem [MAX_CENTERS];
	logic [ROW_W-1:0]    rd_row_q;
	logic [ROW_W-1:0]    wr_row;

	logic                accept;
	logic                complete;
	logic                issue;
	logic                flush;
	logic                hit;
	logic                last_chk;
	logic                dec_idle;
	logic                dec_scan;
	logic                dec_valid;
	logic                dec_full;
	logic                dec_last;
	logic [INDEX_W-1:0]  dec_pid;
	logic                wr_en;

	link_t               links [MAX_DIMS+1];
	logic [COORD_W-1:0]  skew_c [MAX_DIMS];
	logic [COORD_W-1:0]  cell_c [MAX_DIMS];

	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DCNT_W'(1);
		end else if (int'(dims_q) > MAX_DIMS) begin
			dims_eff = DCNT_W'(MAX_DIMS);
		end else begin
			dims_eff = DCNT_W'(dims_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			dims_q   <= DIMS_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_DIMS:   dims_q   <= cfg_data[DIMS_W-1:0];
				default:    ;
			endcase
		end
	end

	assign accept   = start && !busy;
	assign complete = (int'(pos_q) + 1) >= int'(dims_eff);
	assign hit      = links[MAX_DIMS].valid && !links[MAX_DIMS].big &&
	                  (links[MAX_DIMS].sum < radius_q);
	assign last_chk = links[MAX_DIMS].valid &&
	                  ((CNT_W'(chk_slot_q) + CNT_W'(1)) == cnt_q);
	assign dec_full = (cnt_q == CNT_W'(MAX_CENTERS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && complete && (cnt_q != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || last_chk) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		dec_idle = 1'b0;
		dec_scan = 1'b0;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				dec_idle = accept && complete && (cnt_q == '0);
			end
			ST_SCAN: begin
				busy     = 1'b1;
				dec_scan = hit || last_chk;
				issue    = (rd_slot_q != cnt_q) && !dec_scan;
			end
			default: ;
		endcase
	end

	assign dec_valid = dec_idle || dec_scan;
	assign flush     = dec_valid;
	assign dec_pid   = dec_scan ? pid_q : point.point_index;
	assign dec_last  = dec_scan ? last_q : point.last_point;
	assign wr_en     = dec_valid && !(dec_scan && hit) && !dec_full;

	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (k >= int'(dims_eff)) begin
				wr_row[k*COORD_W +: COORD_W] = '0;
			end else if (accept && (int'(pos_q) == k)) begin
				wr_row[k*COORD_W +: COORD_W] = point.coordinate;
			end else begin
				wr_row[k*COORD_W +: COORD_W] = cell_c[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctr_mem[cnt_q[SLOT_W-1:0]] <= wr_row;
		end
		rd_row_q <= ctr_mem[rd_slot_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q  <= point.point_index;
			last_q <= point.last_point;
		end
		if (dec_valid) begin
			res_q.point_echo <= dec_pid;
			if (dec_scan && hit) begin
				res_q.new_center  <= 1'b0;
				res_q.center_slot <= SLOT_OUT_W'(chk_slot_q);
				res_q.store_full  <= 1'b0;
			end else if (dec_full) begin
				res_q.new_center  <= 1'b0;
				res_q.center_slot <= '0;
				res_q.store_full  <= 1'b1;
			end else begin
				res_q.new_center  <= 1'b1;
				res_q.center_slot <= SLOT_OUT_W'(cnt_q);
				res_q.store_full  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			rd_slot_q  <= '0;
			chk_slot_q <= '0;
			tag_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= dec_valid;
			tag_s1  <= issue && !flush;
			if (accept) begin
				pos_q <= complete ? '0 : pos_q + POS_W'(1);
			end
			if (state_q == ST_IDLE) begin
				rd_slot_q  <= '0;
				chk_slot_q <= '0;
			end else begin
				if (issue) begin
					rd_slot_q <= rd_slot_q + CNT_W'(1);
				end
				if (links[MAX_DIMS].valid) begin
					chk_slot_q <= chk_slot_q + SLOT_W'(1);
				end
			end
			if (dec_valid) begin
				if (dec_last) begin
					cnt_q <= '0;
				end else if (wr_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign links[0] = '{valid: tag_s1, big: 1'b0, sum: '0};

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
		if (k == 0) begin : g_direct
			assign skew_c[k] = rd_row_q[COORD_W-1:0];
		end else begin : g_skew
			logic [COORD_W-1:0] dly_q [k];
			always_ff @(posedge clk) begin
				dly_q[0] <= rd_row_q[k*COORD_W +: COORD_W];
				for (int j = 1; j < k; j++) begin
					dly_q[j] <= dly_q[j-1];
				end
			end
			assign skew_c[k] = dly_q[k-1];
		end

		gscc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.flush      (flush),
			.load_en    (accept && (int'(pos_q) == k)),
			.load_coord (point.coordinate),
			.active     (k < int'(dims_eff)),
			.ctr_coord  (skew_c[k]),
			.link_in    (links[k]),
			.link_out   (links[k+1]),
			.coord      (cell_c[k])
		);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
